FILE: rtl/core/csif_pkg.sv
// Shared types and constants of the cross stencil image filter.
`default_nettype none

package csif_pkg;

  // Fixed field widths
  localparam int PIX_W  = 8;
  localparam int CFG_W  = 9;
  localparam int MODE_W = 2;
  localparam int IDX_W  = 2;

  // Default frame limits
  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  // Smallest frame side in use
  localparam int MIN_SIDE = 3;

  // Blur divides by five through a reciprocal: floor(x / 5) = (x * 3277) >> 14
  // holds for every x below 16384.
  localparam int RECIP5       = 3277;
  localparam int RECIP5_SHIFT = 14;

  // Register indexes of the configuration port
  typedef enum logic [IDX_W-1:0] {
    REG_FILTER_MODE  = 2'd0,
    REG_FRAME_WIDTH  = 2'd1,
    REG_FRAME_HEIGHT = 2'd2
  } reg_index_t;

  // Filter modes; the unused code passes pixels through
  typedef enum logic [MODE_W-1:0] {
    MODE_BLUR    = 2'd0,
    MODE_SHARPEN = 2'd1,
    MODE_EDGE    = 2'd2,
    MODE_PASS    = 2'd3
  } filter_mode_t;

  // One input item
  typedef struct packed {
    logic [PIX_W-1:0] pixel_in;
    logic             drain;
  } in_item_t;

  // One result item
  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             frame_last;
  } out_item_t;

endpackage

`default_nettype wire

FILE: rtl/core/cross_stencil_image_filter_core.sv
// Streaming five-point cross stencil filter with a shared line-store memory.
// Throughput: one item per cycle unless a stalled output holds stage 1; the line store is
//   read at transfer and written back when stage 1 advances, with one-entry forwarding
//   covering a read of the column just written. A result passes stage 1, then the output
//   register; without drains a pixel's result comes out frame_width+1 items after the pixel.
// Reset: synchronous; clears counters, window, pipeline and registers (mode blur, 256x256
//   clamped to the limits). The line store is not cleared and holds no valid bits.
`default_nettype none

module cross_stencil_image_filter_core #(
  parameter int MAX_WIDTH  = csif_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = csif_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // input channel
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire csif_pkg::in_item_t                in_data,
  // output channel
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output csif_pkg::out_item_t                    out_data,
  // configuration port
  input  wire logic                              cfg_write,
  input  wire logic [csif_pkg::IDX_W-1:0]        cfg_index,
  input  wire logic [csif_pkg::CFG_W-1:0]        cfg_data
);

  localparam int PW8 = csif_pkg::PIX_W;
  localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int PW  = $clog2(MAX_WIDTH + 2);
  localparam int LWW = (WW > csif_pkg::CFG_W) ? WW : csif_pkg::CFG_W;
  localparam int LHW = (HW > csif_pkg::CFG_W) ? HW : csif_pkg::CFG_W;
  localparam int SUM_W  = 11;
  localparam int PROD_W = SUM_W + 12;
  localparam int SGN_W  = 12;

  // stage-1 control, captured at input transfer
  typedef struct packed {
    logic           is_pix;
    logic           emit;
    logic           use_win;
    logic           border;
    logic           last;
    logic [AW-1:0]  addr;
    logic [PW8-1:0] pix;
  } s1_ctrl_t;

  // configuration
  logic [csif_pkg::MODE_W-1:0] mode;
  logic [WW-1:0]               eff_w;
  logic [HW-1:0]               eff_h;

  // stream position
  logic [AW-1:0] in_col;
  logic [RW-1:0] in_row;
  logic [AW-1:0] out_col;
  logic [RW-1:0] out_row;
  logic [PW-1:0] pending;

  // line store: upper in the high byte, middle in the low byte
  logic [2*PW8-1:0] line_mem [MAX_WIDTH];
  logic [2*PW8-1:0] rdata;
  logic             fwd_hit;
  logic [2*PW8-1:0] fwd_data;

  // stencil window
  logic [PW8-1:0] win [9];
  logic [PW8-1:0] win_next [9];

  // pipeline
  logic      s1_valid;
  s1_ctrl_t  s1;
  s1_ctrl_t  s0;
  logic      adv1;
  logic      in_xfer;

  // stage-0 decode
  logic [PW-1:0]  w_plus1;
  logic           full;
  logic           out_border;
  logic           out_last;
  logic [WW-1:0]  w_m1;
  logic [HW-1:0]  h_m1;
  logic [LWW-1:0] cfg_w_ext;
  logic [LHW-1:0] cfg_h_ext;
  logic [LWW-1:0] cfg_w_clamp;
  logic [LHW-1:0] cfg_h_clamp;

  // stage-1 datapath
  logic [2*PW8-1:0] mem_word;
  logic [PW8-1:0]   up_pix;
  logic [PW8-1:0]   mid_pix;
  logic [SUM_W-1:0] nb_sum;
  logic [SUM_W-1:0] all_sum;
  logic [PROD_W-1:0] blur_prod;
  logic signed [SGN_W-1:0] sharp_val;
  logic signed [SGN_W-1:0] edge_val;
  logic [PW8-1:0]   filt;
  logic [PW8-1:0]   result;

  // handshake
  assign adv1     = s1_valid && !(out_valid && out_stall);
  assign in_stall = s1_valid && !adv1;
  assign in_xfer  = in_valid && !in_stall;

  // clamp the written frame size
  assign cfg_w_ext = LWW'(cfg_data);
  assign cfg_h_ext = LHW'(cfg_data);
  always_comb begin
    if (cfg_w_ext < LWW'(csif_pkg::MIN_SIDE)) begin
      cfg_w_clamp = LWW'(csif_pkg::MIN_SIDE);
    end else if (cfg_w_ext > LWW'(MAX_WIDTH)) begin
      cfg_w_clamp = LWW'(MAX_WIDTH);
    end else begin
      cfg_w_clamp = cfg_w_ext;
    end
    if (cfg_h_ext < LHW'(csif_pkg::MIN_SIDE)) begin
      cfg_h_clamp = LHW'(csif_pkg::MIN_SIDE);
    end else if (cfg_h_ext > LHW'(MAX_HEIGHT)) begin
      cfg_h_clamp = LHW'(MAX_HEIGHT);
    end else begin
      cfg_h_clamp = cfg_h_ext;
    end
  end

  // decode the item at transfer
  assign w_plus1    = PW'(eff_w) + PW'(1);
  assign full       = (pending == w_plus1);
  assign w_m1       = eff_w - WW'(1);
  assign h_m1       = eff_h - HW'(1);
  assign out_last   = (WW'(out_col) == w_m1) && (HW'(out_row) == h_m1);
  assign out_border = (out_col == '0) || (WW'(out_col) == w_m1) ||
                      (out_row == '0) || (HW'(out_row) == h_m1);

  always_comb begin
    s0.is_pix  = !in_data.drain;
    s0.emit    = in_data.drain ? (pending != '0) : full;
    s0.use_win = full;
    s0.border  = out_border;
    s0.last    = out_last;
    s0.addr    = in_data.drain ? out_col : in_col;
    s0.pix     = in_data.pixel_in;
  end

  // configuration and stream counters
  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= csif_pkg::MODE_BLUR;
      eff_w   <= (MAX_WIDTH < 256) ? WW'(MAX_WIDTH) : WW'(256);
      eff_h   <= (MAX_HEIGHT < 256) ? HW'(MAX_HEIGHT) : HW'(256);
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
      pending <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          csif_pkg::REG_FILTER_MODE: begin
            mode <= cfg_data[csif_pkg::MODE_W-1:0];
          end
          csif_pkg::REG_FRAME_WIDTH: begin
            eff_w <= WW'(cfg_w_clamp);
          end
          csif_pkg::REG_FRAME_HEIGHT: begin
            eff_h <= HW'(cfg_h_clamp);
          end
          default: begin
          end
        endcase
      end
      if (cfg_write && (cfg_index == csif_pkg::REG_FRAME_WIDTH ||
                        cfg_index == csif_pkg::REG_FRAME_HEIGHT)) begin
        // restart the stream, drop pending results
        in_col  <= '0;
        in_row  <= '0;
        out_col <= '0;
        out_row <= '0;
        pending <= '0;
      end else if (in_xfer) begin
        if (s0.is_pix) begin
          if (WW'(in_col) == w_m1) begin
            in_col <= '0;
            in_row <= (HW'(in_row) == h_m1) ? '0 : in_row + RW'(1);
          end else begin
            in_col <= in_col + AW'(1);
          end
          if (!full) begin
            pending <= pending + PW'(1);
          end
        end else if (s0.emit) begin
          pending <= pending - PW'(1);
        end
        if (s0.emit) begin
          if (WW'(out_col) == w_m1) begin
            out_col <= '0;
            out_row <= (HW'(out_row) == h_m1) ? '0 : out_row + RW'(1);
          end else begin
            out_col <= out_col + AW'(1);
          end
        end
      end
    end
  end

  // line store: read at transfer, write back when stage 1 advances
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      rdata <= line_mem[s0.addr];
    end
    if (adv1 && s1.is_pix) begin
      line_mem[s1.addr] <= {mid_pix, s1.pix};
    end
  end

  // forward a write that lands on the entry being read
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (in_xfer) begin
      fwd_hit <= adv1 && s1.is_pix && (s1.addr == s0.addr);
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      fwd_data <= {mid_pix, s1.pix};
    end
  end

  // stage-1 register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_xfer) begin
      s1_valid <= 1'b1;
    end else if (adv1) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1 <= s0;
    end
  end

  assign mem_word = fwd_hit ? fwd_data : rdata;
  assign up_pix   = mem_word[2*PW8-1:PW8];
  assign mid_pix  = mem_word[PW8-1:0];

  // shift the window on a pixel
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      win_next[i] = win[i];
    end
    if (s1.is_pix) begin
      for (int r = 0; r < 3; r++) begin
        win_next[r*3]   = win[r*3+1];
        win_next[r*3+1] = win[r*3+2];
      end
      win_next[2] = up_pix;
      win_next[5] = mid_pix;
      win_next[8] = s1.pix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) begin
        win[i] <= '0;
      end
    end else if (adv1) begin
      for (int i = 0; i < 9; i++) begin
        win[i] <= win_next[i];
      end
    end
  end

  // stencil arithmetic on the updated window
  assign nb_sum    = SUM_W'(win_next[1]) + SUM_W'(win_next[3]) +
                     SUM_W'(win_next[5]) + SUM_W'(win_next[7]);
  assign all_sum   = nb_sum + SUM_W'(win_next[4]);
  assign blur_prod = PROD_W'(all_sum) * PROD_W'(csif_pkg::RECIP5);
  assign sharp_val = signed'(SGN_W'(win_next[4]) * SGN_W'(5)) - signed'(SGN_W'(nb_sum));
  assign edge_val  = signed'(SGN_W'(nb_sum)) - signed'(SGN_W'(win_next[4]) << 2);

  always_comb begin
    case (mode)
      csif_pkg::MODE_BLUR: begin
        filt = blur_prod[csif_pkg::RECIP5_SHIFT +: PW8];
      end
      csif_pkg::MODE_SHARPEN: begin
        if (sharp_val < 0) begin
          filt = '0;
        end else if (sharp_val > SGN_W'(255)) begin
          filt = '1;
        end else begin
          filt = sharp_val[PW8-1:0];
        end
      end
      csif_pkg::MODE_EDGE: begin
        if (edge_val < 0) begin
          filt = '0;
        end else if (edge_val > SGN_W'(255)) begin
          filt = '1;
        end else begin
          filt = edge_val[PW8-1:0];
        end
      end
      default: begin
        filt = win_next[4];
      end
    endcase
  end

  // pick the window result, the border pass-through or the stored middle row
  always_comb begin
    if (!s1.use_win) begin
      result = mid_pix;
    end else if (s1.border) begin
      result = win_next[4];
    end else begin
      result = filt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv1 && s1.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && s1.emit) begin
      out_data.pixel_out  <= result;
      out_data.frame_last <= s1.last;
    end
  end

endmodule

`default_nettype wire

FILE: tb/cross_stencil_image_filter_core_tb.sv
// Self-checking testbench for the cross stencil image filter core.
`timescale 1ns / 100ps

module cross_stencil_image_filter_core_tb;
  import csif_pkg::*;

  localparam int QUIET_LIMIT = 2000;   // cycles without any transfer before giving up
  localparam int ITEM_TARGET = 1950;
  localparam int HOLD_OFF    = 300;    // long receiver stall that backs up the input
  localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;  // unmapped register index

  // Stencil predictor and store of pending expected pixels
  class stencil_scoreboard;
    filter_mode_t mode = MODE_BLUR;
    logic [CFG_W-1:0] width_reg = 9'd256;
    logic [CFG_W-1:0] height_reg = 9'd256;
    logic [PIX_W-1:0] upper_line [DEF_MAX_WIDTH] = '{default: 8'h00};
    logic [PIX_W-1:0] middle_line [DEF_MAX_WIDTH] = '{default: 8'h00};
    logic [PIX_W-1:0] win [9] = '{default: 8'h00};
    int col = 0;
    int row = 0;
    int out_pos = 0;
    int errors = 0;
    out_item_t expected_px[$];

    function int side(logic [CFG_W-1:0] v, int max_side);
      if (v < MIN_SIDE) return MIN_SIDE;
      if (v > max_side) return max_side;
      return v;
    endfunction

    function int byte_clamp(int v);
      if (v < 0) return 0;
      if (v > 255) return 255;
      return v;
    endfunction

    function int remaining();
      return expected_px.size();
    endfunction

    // Mirror a register write; a size write restarts the stream
    function void set_register(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_FILTER_MODE: mode = filter_mode_t'(data[MODE_W-1:0]);
        REG_FRAME_WIDTH: begin
          width_reg = data;
          col = 0;
          row = 0;
          out_pos = 0;
        end
        REG_FRAME_HEIGHT: begin
          height_reg = data;
          col = 0;
          row = 0;
          out_pos = 0;
        end
        default: ;
      endcase
    endfunction

    // Advance the predictor by one accepted transfer and queue any result
    function void note_input(in_item_t it);
      int w, h, fsize, in_idx, pend, ox, oy, c, nb, v;
      bit border, fire;
      out_item_t e;
      w = side(width_reg, DEF_MAX_WIDTH);
      h = side(height_reg, DEF_MAX_HEIGHT);
      fsize = w * h;
      in_idx = row * w + col;
      pend = (in_idx + fsize - out_pos) % fsize;
      oy = out_pos / w;
      ox = out_pos % w;
      border = (ox == 0) || (ox == w - 1) || (oy == 0) || (oy == h - 1);
      fire = (pend == w + 1);
      if (it.drain) begin
        if (pend == 0) return;
      end else begin
        // shift the window left and load the new column
        for (int r = 0; r < 3; r++) begin
          win[r * 3] = win[r * 3 + 1];
          win[r * 3 + 1] = win[r * 3 + 2];
        end
        win[2] = upper_line[col];
        win[5] = middle_line[col];
        win[8] = it.pixel_in;
        upper_line[col] = middle_line[col];
        middle_line[col] = it.pixel_in;
        col++;
        if (col >= w) begin
          col = 0;
          row++;
          if (row >= h) row = 0;
        end
        if (!fire) return;
      end
      if (fire && !border) begin
        c = win[4];
        nb = win[1];
        nb += win[3];
        nb += win[5];
        nb += win[7];
        case (mode)
          MODE_BLUR:    v = (nb + c) / 5;
          MODE_SHARPEN: v = byte_clamp(5 * c - nb);
          MODE_EDGE:    v = byte_clamp(nb - 4 * c);
          default:      v = c;
        endcase
      end else if (fire) begin
        v = win[4];
      end else begin
        // lower neighbour missing: the oldest pixel leaves unchanged
        v = middle_line[ox];
      end
      e.pixel_out = v[PIX_W-1:0];
      e.frame_last = (out_pos == fsize - 1);
      expected_px.push_back(e);
      out_pos = (out_pos + 1) % fsize;
    endfunction

    // Compare one output transfer with the oldest expectation
    function void check_result(out_item_t got);
      out_item_t e;
      if (expected_px.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: result with nothing outstanding: pixel %0d last %0b",
                   $time, got.pixel_out, got.frame_last);
        return;
      end
      e = expected_px.pop_front();
      if (got.pixel_out !== e.pixel_out || got.frame_last !== e.frame_last) begin
        errors++;
        if (errors <= 10)
          $display("%0t: mismatch: expected pixel %0d last %0b, got pixel %0d last %0b",
                   $time, e.pixel_out, e.frame_last, got.pixel_out, got.frame_last);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  out_item_t out_data;
  logic cfg_write = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  stencil_scoreboard sb;
  bit send_idle = 1'b1;
  bit recv_idle = 1'b1;
  int pressure_cycles = 0;
  int items_sent = 0;

  cross_stencil_image_filter_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Offer one item, after a random gap if send_idle, and hold it until the transfer
  task automatic push_item(in_item_t it);
    int gap;
    gap = send_idle ? $urandom_range(10) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(it);
    items_sent++;
    @(negedge clk);
  endtask

  // Pixels with an occasional stray drain mixed in
  task automatic stream_pixels(int count, int noise_pct);
    in_item_t it;
    repeat (count) begin
      it.pixel_in = 8'($urandom);
      it.drain = ($urandom_range(99) < noise_pct);
      push_item(it);
    end
  endtask

  task automatic flush_tail(int count);
    in_item_t it;
    repeat (count) begin
      it.pixel_in = 8'($urandom);
      it.drain = 1'b1;
      push_item(it);
    end
  endtask

  // 3x3 frame: one interior pixel surrounded by a constant ring
  task automatic send_cross(logic [PIX_W-1:0] centre, logic [PIX_W-1:0] ring);
    in_item_t it;
    for (int i = 0; i < 9; i++) begin
      it.pixel_in = (i == 4) ? centre : ring;
      it.drain = 1'b0;
      push_item(it);
    end
  endtask

  // Drop valid and wait until every expected result has been taken
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.remaining() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    sb.set_register(idx, data);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Receiver: random stall per result if recv_idle, plus one long hold-off on request
  initial begin : result_sink
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (pressure_cycles > 0) begin
        hold = pressure_cycles;
        pressure_cycles = 0;
      end
      out_stall <= (hold > 0);
      if (hold > 0) hold--;
      @(posedge clk);
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        sb.check_result(out_data);
        hold = recv_idle ? $urandom_range(10) : 0;
      end
    end
  end

  // Abort when no transfer of any kind happens for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
          cfg_write || rst)
        quiet = 0;
      else
        quiet++;
    end
    $display("[cross_stencil_image_filter_core] ERROR");
    $finish;
  end

  initial begin : stimulus
    int phase, pick, px, w, h, noise, ending;
    logic [CFG_W-1:0] w_val, h_val;
    logic [MODE_W-1:0] mode_code;
    logic [6:0] spare;
    bit keep, wide_done;
    sb = new();
    phase = 0;
    wide_done = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Power-up settings: 256 wide, blur; fills every column of the line store
    stream_pixels(262, 0);
    flush_tail(3);
    settle();

    // Edge on a clamped 3x3 frame: saturate high, then steady, early and empty drains
    write_reg(REG_FILTER_MODE, 9'(MODE_EDGE));
    write_reg(REG_FRAME_WIDTH, 9'd0);
    write_reg(REG_FRAME_HEIGHT, 9'd2);
    send_cross(8'd0, 8'd255);
    flush_tail(5);
    settle();

    // Sharpen saturating low; mode written with junk upper bits, spare index ignored
    write_reg(REG_FILTER_MODE, {7'h7F, 2'(MODE_SHARPEN)});
    write_reg(REG_SPARE, 9'h1FF);
    send_cross(8'd0, 8'd255);
    flush_tail(4);

    // Random phases
    while (items_sent < ITEM_TARGET) begin
      settle();
      send_idle = ($urandom_range(3) != 0);
      recv_idle = ($urandom_range(3) != 0);
      mode_code = ($urandom_range(7) == 0) ? 2'(MODE_PASS) : 2'($urandom_range(2));
      spare = ($urandom_range(3) == 0) ? 7'($urandom) : 7'd0;
      write_reg(REG_FILTER_MODE, {spare, mode_code});

      pick = $urandom_range(15);
      if (phase == 0) begin
        w_val = 9'd4;
        h_val = 9'd4;
      end else if (pick == 0 && !wide_done) begin
        w_val = 9'($urandom_range(257, 511));
        h_val = 9'd3;
        wide_done = 1'b1;
      end else if (pick == 1) begin
        w_val = 9'($urandom_range(3, 5));
        h_val = 9'($urandom_range(257, 511));
      end else if (pick == 2) begin
        w_val = 9'($urandom_range(0, 2));
        h_val = 9'($urandom_range(0, 2));
      end else begin
        w_val = 9'($urandom_range(3, 12));
        h_val = 9'($urandom_range(3, 6));
      end

      // sometimes carry the stream on across the phase without a restart
      keep = (phase != 0) && (pick > 2) && ($urandom_range(3) == 0) &&
             (sb.side(sb.width_reg, DEF_MAX_WIDTH) <= 12) &&
             (sb.side(sb.height_reg, DEF_MAX_HEIGHT) <= 6);
      if (!keep) begin
        if ($urandom_range(1) == 0) begin
          write_reg(REG_FRAME_WIDTH, w_val);
          write_reg(REG_FRAME_HEIGHT, h_val);
        end else begin
          write_reg(REG_FRAME_HEIGHT, h_val);
          write_reg(REG_FRAME_WIDTH, w_val);
        end
      end

      w = sb.side(sb.width_reg, DEF_MAX_WIDTH);
      h = sb.side(sb.height_reg, DEF_MAX_HEIGHT);
      if (w > 12) px = 2 * w + $urandom_range(2, 10);
      else if (h > 6) px = $urandom_range(20, 40);
      else px = $urandom_range(1, 3) * w * h + $urandom_range(0, w);
      noise = ($urandom_range(9) == 0) ? 5 : 0;

      // back up the block: sender runs flat out while the receiver holds off
      if (phase == 0) begin
        px = 64;
        noise = 0;
        send_idle = 1'b0;
        pressure_cycles = HOLD_OFF;
      end

      stream_pixels(px, noise);
      ending = $urandom_range(5);
      if (ending == 1) flush_tail($urandom_range(1, w));
      else if (ending > 1) flush_tail(w + 1 + $urandom_range(0, 2));
      phase++;
    end

    settle();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.remaining() == 0)
      $display("[cross_stencil_image_filter_core] OK");
    else
      $display("[cross_stencil_image_filter_core] ERROR");
    $finish;
  end

endmodule
